// ----- src/suffix_automaton_extend_macros.svh -----
// ----------------------------------------------------------------------------
// Suffix automaton extend: assertion macros
// Shorthand for the concurrent checks used inside the engine. Each macro
// samples on clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SUFFIX_AUTOMATON_EXTEND_MACROS_SVH
`define SUFFIX_AUTOMATON_EXTEND_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define SAE_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SAE_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sae_pkg.sv -----
// ----------------------------------------------------------------------------
// Suffix automaton extend: shared package
// Field widths, default sizes, status codes and the request and response
// types of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package sae_pkg;

	localparam int ALPHABET_DEF   = 10;
	localparam int MAX_STATES_DEF = 4096;

	localparam int SYM_W  = 4;
	localparam int PREV_W = 12;
	localparam int NEW_W  = 12;
	localparam int CNT_W  = 25;
	localparam int STAT_W = 2;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 40;

	localparam logic [CNT_W-1:0] TOTAL_MAX = {CNT_W{1'b1}};

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_BAD_PREV = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ALU_INC = 2'd0,
		ALU_SUB = 2'd1,
		ALU_SAT = 2'd2
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [CNT_W-1:0] a;
		logic [CNT_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] y;
		logic             eq;
	} alu_rsp_t;

endpackage

// ----- src/sae_ram.sv -----
// ----------------------------------------------------------------------------
// Suffix automaton extend: simple dual-port RAM
// One write port and one read port with a registered read that holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module sae_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/sae_alu.sv -----
// ----------------------------------------------------------------------------
// Suffix automaton extend: shared arithmetic unit
// Increment, clamped subtract and saturating add, plus an equality flag
// that is valid for every operation.
// ----------------------------------------------------------------------------
module sae_alu (
	input  sae_pkg::alu_req_t req,
	output sae_pkg::alu_rsp_t rsp
);
	import sae_pkg::*;

	logic [CNT_W:0] sum;

	always_comb begin
		sum    = {1'b0, req.a} + {1'b0, req.b};
		rsp.eq = (req.a == req.b);
		unique case (req.op)
			ALU_INC: rsp.y = req.a + CNT_W'(1);
			ALU_SUB: rsp.y = (req.a > req.b) ? (req.a - req.b) : '0;
			// The limit is all ones, so a carry out means the sum went past it.
			ALU_SAT: rsp.y = sum[CNT_W] ? TOTAL_MAX : sum[CNT_W-1:0];
			default: rsp.y = '0;
		endcase
	end

endmodule

// ----- src/sae_ctrl.sv -----
// ----------------------------------------------------------------------------
// Suffix automaton extend: sequencer
// Steps one extend operation through the state tables: suffix-link walks,
// cloning with a row copy, redirection and the running substring count.
// ----------------------------------------------------------------------------
`include "suffix_automaton_extend_macros.svh"

module sae_ctrl #(
	parameter int ALPHABET   = sae_pkg::ALPHABET_DEF,
	parameter int MAX_STATES = sae_pkg::MAX_STATES_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [sae_pkg::SYM_W-1:0]                sym,
	input  logic [sae_pkg::PREV_W-1:0]               prev,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [sae_pkg::NEW_W-1:0]                new_state,
	output logic [sae_pkg::CNT_W-1:0]                distinct_count,
	output logic [sae_pkg::STAT_W-1:0]               status,
	output sae_pkg::alu_req_t                        alu_req,
	input  sae_pkg::alu_rsp_t                        alu_rsp,
	output logic                                     tr_we,
	output logic [$clog2(MAX_STATES*ALPHABET)-1:0]   tr_waddr,
	output logic [$clog2(MAX_STATES)-1:0]            tr_wdata,
	output logic                                     tr_re,
	output logic [$clog2(MAX_STATES*ALPHABET)-1:0]   tr_raddr,
	input  logic [$clog2(MAX_STATES)-1:0]            tr_rdata,
	output logic [$clog2(MAX_STATES)-1:0]            nd_waddr,
	output logic                                     link_we,
	output logic [$clog2(MAX_STATES)-1:0]            link_wdata,
	output logic                                     len_we,
	output logic [$clog2(MAX_STATES)-1:0]            len_wdata,
	output logic                                     nd_re,
	output logic [$clog2(MAX_STATES)-1:0]            nd_raddr,
	input  logic [$clog2(MAX_STATES)-1:0]            link_rdata,
	input  logic [$clog2(MAX_STATES)-1:0]            len_rdata
);
	import sae_pkg::*;

	localparam int SW     = $clog2(MAX_STATES);
	localparam int TDEPTH = MAX_STATES * ALPHABET;
	localparam int TAW    = $clog2(TDEPTH);
	localparam int CW     = $clog2(ALPHABET);
	localparam int KW     = $clog2(ALPHABET + 1);
	localparam int GW     = $clog2(MAX_STATES + 1);
	localparam int XW     = (SW > NEW_W) ? SW : NEW_W;

	localparam logic [TAW-1:0] ALPHA_T = TAW'(ALPHABET);

	typedef enum logic [14:0] {
		S_CLEAR = 15'h0001,
		S_IDLE  = 15'h0002,
		S_LENP  = 15'h0004,
		S_WRD   = 15'h0008,
		S_WCHK  = 15'h0010,
		S_QP    = 15'h0020,
		S_QCHK  = 15'h0040,
		S_CLONE = 15'h0080,
		S_LNKQ  = 15'h0100,
		S_LNKNP = 15'h0200,
		S_CP    = 15'h0400,
		S_FINRD = 15'h0800,
		S_FIN   = 15'h1000,
		S_TOT   = 15'h2000,
		S_EMIT  = 15'h4000
	} state_t;

	state_t state_q, state_d;

	logic [TAW-1:0]   clr_q;
	logic [SW-1:0]    su_q;
	logic [CNT_W-1:0] total_q;
	logic             out_valid_q;
	logic             walk2_q;
	logic [GW-1:0]    guard_q;
	logic [KW-1:0]    k_q;

	logic [CW-1:0]    c_q;
	logic [SW-1:0]    p_q;
	logic [SW-1:0]    q_q;
	logic [SW-1:0]    np_q;
	logic [SW-1:0]    nq_q;
	logic [SW-1:0]    lennp_q;
	logic [SW-1:0]    lenp1_q;
	logic [SW-1:0]    qlink_q;
	logic [SW-1:0]    linknp_q;
	logic [SW-1:0]    d_q;
	logic [NEW_W-1:0] res_state_q;
	status_t          res_status_q;
	logic [NEW_W-1:0] out_state_q;
	logic [CNT_W-1:0] out_count_q;
	status_t          out_status_q;

	logic [6:0]    sym_r;
	logic [CW-1:0] c_in;
	logic [XW-1:0] prev_x;
	logic [XW-1:0] su_x;
	logic [XW-1:0] np_x;
	logic          acc;
	logic          full;
	logic          bad;
	logic          err;
	logic          p_zero;
	logic          guard_ok;
	logic          walk_more;
	logic          out_load;
	logic          clr_node;

	logic [SW-1:0] tr_rrow;
	logic [KW-1:0] tr_rcol;
	logic [SW-1:0] tr_wrow;
	logic [KW-1:0] tr_wcol;

	function automatic logic [TAW-1:0] tr_addr(input logic [SW-1:0] row,
		input logic [KW-1:0] col);
		return TAW'(row) * ALPHA_T + TAW'(col);
	endfunction

	// Symbols at or above the alphabet size wrap around.
	always_comb begin
		sym_r = 7'(sym);
		for (int i = 0; i < 8; i++) begin
			if (sym_r >= 7'(ALPHABET)) begin
				sym_r = sym_r - 7'(ALPHABET);
			end
		end
	end
	assign c_in = sym_r[CW-1:0];

	assign prev_x    = XW'(prev);
	assign su_x      = XW'(su_q);
	assign np_x      = XW'(np_q);
	assign s_tready  = (state_q == S_IDLE);
	assign acc       = s_tvalid && s_tready;
	assign full      = {1'b0, su_q} >= (SW+1)'(MAX_STATES - 2);
	assign bad       = (prev_x == '0) || (prev_x > su_x);
	assign err       = full || bad;
	assign p_zero    = (p_q == '0);
	assign guard_ok  = (guard_q != GW'(MAX_STATES));
	assign walk_more = alu_rsp.eq && guard_ok;
	assign out_load  = (state_q == S_EMIT) && (!out_valid_q || m_tready);
	assign clr_node  = (clr_q < TAW'(MAX_STATES));

	always_comb begin
		state_d     = state_q;
		alu_req.op  = ALU_INC;
		alu_req.a   = '0;
		alu_req.b   = '0;
		tr_re       = 1'b0;
		tr_rrow     = p_q;
		tr_rcol     = KW'(c_q);
		tr_we       = 1'b0;
		tr_wrow     = p_q;
		tr_wcol     = KW'(c_q);
		tr_wdata    = walk2_q ? nq_q : np_q;
		nd_re       = 1'b0;
		nd_raddr    = p_q;
		nd_waddr    = np_q;
		link_we     = 1'b0;
		link_wdata  = '0;
		len_we      = 1'b0;
		len_wdata   = '0;
		unique case (state_q)
			S_CLEAR: begin
				tr_we    = 1'b1;
				tr_wdata = '0;
				nd_waddr = clr_q[SW-1:0];
				link_we  = clr_node;
				len_we   = clr_node;
				if (clr_q == TAW'(TDEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				alu_req.a = CNT_W'(su_q);
				nd_re     = acc;
				nd_raddr  = prev_x[SW-1:0];
				if (acc) begin
					state_d = err ? S_EMIT : S_LENP;
				end
			end
			S_LENP: begin
				alu_req.a = CNT_W'(len_rdata);
				len_we    = 1'b1;
				len_wdata = alu_rsp.y[SW-1:0];
				state_d   = S_WRD;
			end
			S_WRD: begin
				if (p_zero) begin
					// The walk fell off the root: the new state links to the root.
					link_we    = !walk2_q;
					link_wdata = SW'(1);
					state_d    = S_FINRD;
				end else begin
					tr_re   = 1'b1;
					nd_re   = 1'b1;
					state_d = S_WCHK;
				end
			end
			S_WCHK: begin
				alu_req.a = CNT_W'(tr_rdata);
				alu_req.b = walk2_q ? CNT_W'(q_q) : '0;
				tr_we     = walk_more;
				if (walk_more) begin
					state_d = S_WRD;
				end else begin
					state_d = walk2_q ? S_FINRD : S_QP;
				end
			end
			S_QP: begin
				alu_req.a = CNT_W'(len_rdata);
				nd_re     = 1'b1;
				nd_raddr  = q_q;
				state_d   = S_QCHK;
			end
			S_QCHK: begin
				alu_req.a = CNT_W'(len_rdata);
				alu_req.b = CNT_W'(lenp1_q);
				if (alu_rsp.eq) begin
					link_we    = 1'b1;
					link_wdata = q_q;
					state_d    = S_FINRD;
				end else begin
					state_d = S_CLONE;
				end
			end
			S_CLONE: begin
				alu_req.a  = CNT_W'(su_q);
				nd_waddr   = alu_rsp.y[SW-1:0];
				link_we    = 1'b1;
				link_wdata = qlink_q;
				len_we     = 1'b1;
				len_wdata  = lenp1_q;
				state_d    = S_LNKQ;
			end
			S_LNKQ: begin
				nd_waddr   = q_q;
				link_we    = 1'b1;
				link_wdata = nq_q;
				state_d    = S_LNKNP;
			end
			S_LNKNP: begin
				link_we    = 1'b1;
				link_wdata = nq_q;
				state_d    = S_CP;
			end
			S_CP: begin
				// Row copy: read the source entry, write the one read in the previous cycle.
				tr_re    = (k_q != KW'(ALPHABET));
				tr_rrow  = q_q;
				tr_rcol  = k_q;
				tr_we    = (k_q != '0);
				tr_wrow  = nq_q;
				tr_wcol  = k_q - KW'(1);
				tr_wdata = tr_rdata;
				if (k_q == KW'(ALPHABET)) begin
					state_d = S_WRD;
				end
			end
			S_FINRD: begin
				nd_re    = 1'b1;
				nd_raddr = linknp_q;
				state_d  = S_FIN;
			end
			S_FIN: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = CNT_W'(lennp_q);
				alu_req.b  = CNT_W'(len_rdata);
				state_d    = S_TOT;
			end
			S_TOT: begin
				alu_req.op = ALU_SAT;
				alu_req.a  = total_q;
				alu_req.b  = CNT_W'(d_q);
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	assign tr_raddr = tr_addr(tr_rrow, tr_rcol);
	assign tr_waddr = (state_q == S_CLEAR) ? clr_q : tr_addr(tr_wrow, tr_wcol);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			su_q        <= SW'(1);
			total_q     <= '0;
			out_valid_q <= 1'b0;
			walk2_q     <= 1'b0;
			guard_q     <= '0;
			k_q         <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + TAW'(1);
			end
			if (acc) begin
				walk2_q <= 1'b0;
				guard_q <= '0;
				if (!err) begin
					su_q <= alu_rsp.y[SW-1:0];
				end
			end
			if (state_q == S_WCHK && walk_more) begin
				guard_q <= guard_q + GW'(1);
			end
			if (state_q == S_CLONE) begin
				su_q <= alu_rsp.y[SW-1:0];
			end
			if (state_q == S_LNKNP) begin
				k_q <= '0;
			end
			if (state_q == S_CP) begin
				if (k_q == KW'(ALPHABET)) begin
					walk2_q <= 1'b1;
					guard_q <= '0;
				end else begin
					k_q <= k_q + KW'(1);
				end
			end
			if (state_q == S_TOT) begin
				total_q <= alu_rsp.y;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			c_q  <= c_in;
			p_q  <= prev_x[SW-1:0];
			np_q <= alu_rsp.y[SW-1:0];
			if (err) begin
				res_state_q  <= '0;
				res_status_q <= full ? STAT_FULL : STAT_BAD_PREV;
			end
		end
		if (state_q == S_LENP) begin
			lennp_q <= alu_rsp.y[SW-1:0];
		end
		if (state_q == S_WRD && p_zero && !walk2_q) begin
			linknp_q <= SW'(1);
		end
		if (state_q == S_WCHK) begin
			if (walk_more) begin
				p_q <= link_rdata;
			end else if (!walk2_q) begin
				q_q <= tr_rdata;
			end
		end
		if (state_q == S_QP) begin
			lenp1_q <= alu_rsp.y[SW-1:0];
		end
		if (state_q == S_QCHK) begin
			if (alu_rsp.eq) begin
				linknp_q <= q_q;
			end else begin
				qlink_q <= link_rdata;
			end
		end
		if (state_q == S_CLONE) begin
			nq_q     <= alu_rsp.y[SW-1:0];
			linknp_q <= alu_rsp.y[SW-1:0];
		end
		if (state_q == S_FIN) begin
			d_q <= alu_rsp.y[SW-1:0];
		end
		if (state_q == S_TOT) begin
			res_state_q  <= np_x[NEW_W-1:0];
			res_status_q <= STAT_OK;
		end
		if (out_load) begin
			out_state_q  <= res_state_q;
			out_count_q  <= total_q;
			out_status_q <= res_status_q;
		end
	end

	assign m_tvalid       = out_valid_q;
	assign new_state      = out_state_q;
	assign distinct_count = out_count_q;
	assign status         = out_status_q;

	`SAE_ASSERT_NXT(a_err_keeps_states, acc && err, su_q == $past(su_q),
		"rejected transaction changed the state count")
	`SAE_ASSERT_NXT(a_total_monotonic, 1'b1, total_q >= $past(total_q),
		"substring total decreased")
	`SAE_ASSERT_IMP(a_clone_rows_differ, state_q == S_CP, nq_q != q_q,
		"clone row copy reads and writes the same row")
	`SAE_ASSERT_IMP(a_walk_not_null, state_q == S_WCHK, p_q != '0,
		"suffix walk touched the null state")

endmodule

// ----- src/suffix_automaton_extend.sv -----
// ----------------------------------------------------------------------------
// Suffix automaton extend
// Builds a generalized suffix automaton one symbol at a time, each symbol
// extending from any earlier state, and reports the distinct substring count.
// ----------------------------------------------------------------------------
// Usage: the slave channel takes one transaction per extend: a symbol and the
// state to extend from (1 is the root). The master channel returns exactly one
// transaction for each: the new state index, the running substring count and
// a status (ok, store full, unknown previous state) in tuser.
// After reset the engine clears its tables, one transition entry per cycle,
// all MAX_STATES * ALPHABET entries (40960 by default), with s_tready low.
// An extend walks suffix links until the walk runs off the root or stops at an
// existing transition; a clone adds a row copy of ALPHABET entries and a
// redirect walk, which may stop early. A rejected transaction skips the walk.
// Each walk step is a table read and a compare in the adder.
// s_tready is high only while the sequencer is idle; the result goes valid as
// s_tready rises. An output register lets the next extend start while a result
// waits; a longer stall holds the following result until the register frees.
// ----------------------------------------------------------------------------
module suffix_automaton_extend #(
	parameter int ALPHABET   = sae_pkg::ALPHABET_DEF,
	parameter int MAX_STATES = sae_pkg::MAX_STATES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// symbol [3:0], prev_state [15:4]
	input  logic [sae_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// new_state [11:0], distinct_count [36:12], zero fill [39:37]
	output logic [sae_pkg::M_TDATA_W-1:0]     m_tdata,
	// status [1:0]
	output logic [sae_pkg::STAT_W-1:0]        m_tuser
);
	import sae_pkg::*;

	localparam int SW     = $clog2(MAX_STATES);
	localparam int TDEPTH = MAX_STATES * ALPHABET;
	localparam int TAW    = $clog2(TDEPTH);
	localparam int FILL_W = M_TDATA_W - NEW_W - CNT_W;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic             tr_we;
	logic [TAW-1:0]   tr_waddr;
	logic [SW-1:0]    tr_wdata;
	logic             tr_re;
	logic [TAW-1:0]   tr_raddr;
	logic [SW-1:0]    tr_rdata;
	logic [SW-1:0]    nd_waddr;
	logic             link_we;
	logic [SW-1:0]    link_wdata;
	logic             len_we;
	logic [SW-1:0]    len_wdata;
	logic             nd_re;
	logic [SW-1:0]    nd_raddr;
	logic [SW-1:0]    link_rdata;
	logic [SW-1:0]    len_rdata;
	logic [NEW_W-1:0] new_state;
	logic [CNT_W-1:0] distinct_count;

	sae_ctrl #(
		.ALPHABET   (ALPHABET),
		.MAX_STATES (MAX_STATES)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.sym            (s_tdata[SYM_W-1:0]),
		.prev           (s_tdata[SYM_W+PREV_W-1:SYM_W]),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.new_state      (new_state),
		.distinct_count (distinct_count),
		.status         (m_tuser),
		.alu_req        (alu_req),
		.alu_rsp        (alu_rsp),
		.tr_we          (tr_we),
		.tr_waddr       (tr_waddr),
		.tr_wdata       (tr_wdata),
		.tr_re          (tr_re),
		.tr_raddr       (tr_raddr),
		.tr_rdata       (tr_rdata),
		.nd_waddr       (nd_waddr),
		.link_we        (link_we),
		.link_wdata     (link_wdata),
		.len_we         (len_we),
		.len_wdata      (len_wdata),
		.nd_re          (nd_re),
		.nd_raddr       (nd_raddr),
		.link_rdata     (link_rdata),
		.len_rdata      (len_rdata)
	);

	sae_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	sae_ram #(
		.WIDTH (SW),
		.DEPTH (TDEPTH)
	) u_trans_ram (
		.clk   (clk),
		.we    (tr_we),
		.waddr (tr_waddr),
		.wdata (tr_wdata),
		.re    (tr_re),
		.raddr (tr_raddr),
		.rdata (tr_rdata)
	);

	sae_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_STATES)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (nd_waddr),
		.wdata (link_wdata),
		.re    (nd_re),
		.raddr (nd_raddr),
		.rdata (link_rdata)
	);

	sae_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_STATES)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (nd_waddr),
		.wdata (len_wdata),
		.re    (nd_re),
		.raddr (nd_raddr),
		.rdata (len_rdata)
	);

	assign m_tdata = {{FILL_W{1'b0}}, distinct_count, new_state};

endmodule
